// ===== hdl/bclc_pkg.sv =====
// Package for the baseline calibrated level classifier.
// Holds widths, constants, the controller state type and the command and status structs.
// No dependencies.
package bclc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CNT_W           = 11;
  localparam int SUM_W           = 22;
  localparam int BASE_W          = 12;
  localparam int THR_W           = 13;
  localparam int LVL_W           = 2;
  localparam int NUM_THR         = 3;
  localparam int THR_IDX_W       = 2;
  localparam int DIV_STEPS       = SUM_W;
  localparam int STEP_W          = 5;
  localparam int NUM_W           = 4;
  localparam int PROD_W          = BASE_W + NUM_W;
  localparam int RECIP_W         = 16;
  localparam int RECIP_SHIFT     = 18;

  localparam logic [CNT_W-1:0]   CNT_RESET = CNT_W'(100);
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [RECIP_W-1:0] RECIP_5   = 16'hCCCD;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BASE,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 accept;
    logic                 emit_item;
    logic                 div_step;
    logic                 base_load;
    logic                 thr_mul;
    logic                 thr_scale;
    logic [THR_IDX_W-1:0] thr_idx;
    logic                 emit_final;
  } cmd_t;

  typedef struct packed {
    logic needs_final;
  } sts_t;

  // Threshold percentages 120, 140 and 180 reduced over 100 to a ratio of fifths.
  function automatic logic [NUM_W-1:0] thr_num(input logic [THR_IDX_W-1:0] idx);
    logic [NUM_W-1:0] num;
    unique case (idx)
      2'd0:    num = NUM_W'(120 / 20);
      2'd1:    num = NUM_W'(140 / 20);
      2'd2:    num = NUM_W'(180 / 20);
      default: num = '0;
    endcase
    return num;
  endfunction

endpackage

// ===== hdl/bclc_datapath.sv =====
// Datapath of the level classifier: accumulator, serial divider, threshold scaling,
// classifier and result register. Driven by bclc_controller through cmd_t.
// Depends on bclc_pkg.
module bclc_datapath import bclc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_data_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output logic [LVL_W-1:0]       level_o,
  output logic                   calibrated_o,
  output logic [BASE_W-1:0]      baseline_o
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  taken_q;
  logic [LVL_W-1:0]  spin_q;
  logic              cal_q;
  logic [BASE_W-1:0] base_q;
  logic [THR_W-1:0]  thr_q [NUM_THR];
  logic [LVL_W-1:0]  held_q;

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [PROD_W-1:0] prod_q;

  logic [LVL_W-1:0]  level_q;
  logic              cal_out_q;
  logic [BASE_W-1:0] base_out_q;

  logic [SUM_W:0]               sum_ext;
  logic [SUM_W-1:0]             sum_sat;
  logic [LVL_W-1:0]             spin_nxt;
  logic [CMP_W-1:0]             samp_c;
  logic [LVL_W-1:0]             cls;
  logic [CNT_W:0]               shifted;
  logic [CNT_W+1:0]             trial;
  logic                         ge;
  logic [PROD_W+RECIP_W-1:0]    scaled;
  logic                         needs_final;

  assign sum_ext  = {1'b0, sum_q} + {(SUM_W + 1 - SAMPLE_BITS)'(0), sample_i};
  assign sum_sat  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  assign spin_nxt = spin_q + LVL_W'(1);
  assign samp_c   = CMP_W'(sample_i);
  assign needs_final = !cal_q && (taken_q >= count_q);
  assign sts_o.needs_final = needs_final;

  always_comb begin
    if (samp_c > CMP_W'(thr_q[2])) begin
      cls = LVL_W'(3);
    end else if (samp_c > CMP_W'(thr_q[1])) begin
      cls = LVL_W'(2);
    end else if (samp_c > CMP_W'(thr_q[0])) begin
      cls = LVL_W'(1);
    end else begin
      cls = LVL_W'(0);
    end
  end

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, count_q};
  assign ge      = !trial[CNT_W+1];
  assign rem_d   = ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
  assign quo_d   = {quo_q[SUM_W-2:0], ge};
  assign scaled  = prod_q * RECIP_5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
      sum_q   <= '0;
      taken_q <= '0;
      spin_q  <= '0;
      cal_q   <= 1'b0;
      base_q  <= '0;
      thr_q   <= '{default: '0};
      held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (cal_q) begin
          held_q <= cls;
        end else begin
          spin_q <= spin_nxt;
          if (!needs_final) begin
            sum_q   <= sum_sat;
            taken_q <= taken_q + CNT_W'(1);
            held_q  <= spin_nxt;
          end
        end
      end
      if (cmd_i.base_load) begin
        base_q <= (count_q == '0) ? '0 : quo_q[BASE_W-1:0];
      end
      if (cmd_i.thr_scale) begin
        thr_q[cmd_i.thr_idx] <= scaled[RECIP_SHIFT +: THR_W];
      end
      if (cmd_i.emit_final) begin
        cal_q   <= 1'b1;
        taken_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.thr_mul) begin
      prod_q <= PROD_W'(base_q * thr_num(cmd_i.thr_idx));
    end
    if (cmd_i.emit_item) begin
      level_q    <= cal_q ? cls : spin_nxt;
      cal_out_q  <= cal_q;
      base_out_q <= cal_q ? base_q : '0;
    end else if (cmd_i.emit_final) begin
      level_q    <= held_q;
      cal_out_q  <= 1'b1;
      base_out_q <= base_q;
    end
  end

  assign level_o      = level_q;
  assign calibrated_o = cal_out_q;
  assign baseline_o   = base_out_q;

endmodule

// ===== hdl/bclc_controller.sv =====
// Controller of the level classifier: request handshakes and the finalize sequence
// (serial divide, baseline load, threshold scaling). Depends on bclc_pkg.
module bclc_controller import bclc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e               state_q, state_d;
  logic [STEP_W-1:0]    step_q;
  logic [THR_IDX_W-1:0] idx_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == ST_IDLE) && out_free && in_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.needs_final) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_BASE;
        end
      end
      ST_BASE:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: begin
        state_d = (idx_q == THR_IDX_W'(NUM_THR - 1)) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.emit_item  = accept && !sts_i.needs_final;
    cmd_o.thr_idx    = idx_q;
    unique case (state_q)
      ST_IDLE:  ;
      ST_DIV:   cmd_o.div_step   = 1'b1;
      ST_BASE:  cmd_o.base_load  = 1'b1;
      ST_MUL:   cmd_o.thr_mul    = 1'b1;
      ST_SCALE: cmd_o.thr_scale  = 1'b1;
      ST_DONE:  cmd_o.emit_final = out_free;
      default:  ;
    endcase
    in_stall_o  = !((state_q == ST_IDLE) && out_free);
    out_valid_d = (cmd_o.emit_item || cmd_o.emit_final) ? 1'b1
                                                        : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_DIV) begin
        step_q <= (step_q == STEP_W'(DIV_STEPS - 1)) ? '0 : step_q + STEP_W'(1);
      end
      if (state_q == ST_SCALE) begin
        idx_q <= (idx_q == THR_IDX_W'(NUM_THR - 1)) ? '0 : idx_q + THR_IDX_W'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/baseline_calibrated_level_classifier.sv =====
// Top level of the baseline calibrated level classifier. Depends on bclc_pkg.
// Input request: in_valid_i / in_stall_o with sample_i. Output request: out_valid_o /
// out_stall_i with level_o, calibrated_o and baseline_o. One result per sample.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_data_i, the number of samples
// averaged; write it only while the block is idle. cfg_ready_o is always high.
// Until calibrated, samples are summed and level_o shows a two-bit spinner. The sample
// after sample_count samples finalizes: a 22-step serial divider forms the baseline,
// then three thresholds are scaled on the shared multiplier, each by a multiply and a
// scale state. Later samples are classified. An accumulated or classified sample
// shows its result in the cycle after it is taken; a new sample can be taken every
// cycle while the output is not stalled. The input stalls while the finalizing sample
// runs the divide, baseline load and scaling. The result register holds while
// out_stall_i is high; a new sample is taken in the cycle that register drains. Reset
// loads sample_count with 100 and clears all but divider, product and result data.
module baseline_calibrated_level_classifier import bclc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LVL_W-1:0]       level_o,
  output logic                   calibrated_o,
  output logic [BASE_W-1:0]      baseline_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CNT_W-1:0]       cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bclc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bclc_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (sample_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .level_o      (level_o),
    .calibrated_o (calibrated_o),
    .baseline_o   (baseline_o)
  );

endmodule

// ===== hdl/bclc_checker.sv =====
// Port-level checker for the level classifier, bound to the top level.
// Depends on bclc_pkg.
module bclc_checker import bclc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [LVL_W-1:0]  level_o,
  input logic              calibrated_o,
  input logic [BASE_W-1:0] baseline_o
);

  logic seen_cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_cal_q <= 1'b0;
    end else if (out_valid_o && calibrated_o) begin
      seen_cal_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(level_o) && $stable(calibrated_o) && $stable(baseline_o))
    else $error("stalled output payload changed");

  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_cal_q |-> calibrated_o)
    else $error("calibrated dropped after calibration");

  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !calibrated_o |-> baseline_o == '0)
    else $error("baseline nonzero before calibration");

endmodule

bind baseline_calibrated_level_classifier bclc_checker u_bclc_checker (.*);
